>>> rtl/scfp_pkg.sv
`default_nettype none
package scfp_pkg;

    typedef enum logic [2:0] {
        ST_HEADER = 3'd0,
        ST_BLOCK  = 3'd1,
        ST_XFC    = 3'd2,
        ST_XTO    = 3'd3,
        ST_ADR    = 3'd4,
        ST_VER    = 3'd5
    } t_state;

    localparam logic [2:0] EV_VERSION = 3'd0;
    localparam logic [2:0] EV_BLOCK   = 3'd1;
    localparam logic [2:0] EV_XFC     = 3'd2;
    localparam logic [2:0] EV_XTO     = 3'd3;
    localparam logic [2:0] EV_ADR     = 3'd4;
    localparam logic [2:0] EV_SYNC    = 3'd5;

    localparam logic [1:0] CFG_BLOCK_LEN = 2'd0;
    localparam logic [1:0] CFG_XFER_LEN  = 2'd1;
    localparam logic [1:0] CFG_ADR_LEN   = 2'd2;

    localparam logic [7:0] LEN_RESET = 8'd16;

    // window byte [0] is the oldest character
    localparam logic [3:0][7:0] HDR_VER = 32'h3E524556;
    localparam logic [3:0][7:0] HDR_RQB = 32'h3E425152;
    localparam logic [3:0][7:0] HDR_ADR = 32'h3E524441;
    localparam logic [3:0][7:0] HDR_BST = 32'h3E545342;
    localparam logic [3:0][7:0] HDR_XFC = 32'h3E434658;
    localparam logic [3:0][7:0] HDR_XTO = 32'h3E4F5458;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload;
        logic [7:0]  index;
        logic        last;
        logic [15:0] version;
    } t_result;

    // {valid, digit}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = {1'b1, 4'(c - 8'h37)};
        end
        return d;
    endfunction

    function automatic logic [15:0] parse_version(input logic [3:0][7:0] w);
        logic [15:0] v;
        logic        run;
        logic [4:0]  d;
        v   = '0;
        run = 1'b1;
        for (int i = 0; i < 4; i++) begin
            d = hex_digit(w[i]);
            if (run && d[4]) begin
                v = {v[11:0], d[3:0]};
            end else begin
                run = 1'b0;
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/serial_command_frame_parser.sv
// Serial command frame parser.
// Slave stream: one received serial byte per request on i_s_tdata.
// Master stream: zero or one event per byte. o_m_tuser carries the event kind
// (0 version, 1 block request, 2 transfer complete, 3 transfer timeout,
// 4 data request, 5 sync burst), o_m_tlast marks the final payload byte.
// Config channel: i_cfg_index selects 0 block request length, 1 transfer
// result length, 2 data request length; other indexes are ignored. Write only
// while idle; o_cfg_ready is always high.
// An event appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the receiver stalls, set by the single
// output register. When the receiver stalls with an event held, o_s_tready
// drops until it is taken; the held event stays stable.
// Reset (synchronous, active low) returns the parser to header search with
// an empty window, sets all lengths to 16 and empties the output register.
`default_nettype none
module serial_command_frame_parser
    import scfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [7:0] payload_byte, [15:8] byte_index,
                                          // [31:16] version_value
    output logic [2:0]       o_m_tuser,   // [2:0] event_kind
    output logic             o_m_tlast,   // last_byte
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    logic [7:0] r_block_len, r_xfer_len, r_adr_len;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_accept;
    logic       w_res_valid;
    t_result    w_res;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign w_accept    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_len <= LEN_RESET;
            r_xfer_len  <= LEN_RESET;
            r_adr_len   <= LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BLOCK_LEN: r_block_len <= i_cfg_data;
                CFG_XFER_LEN:  r_xfer_len  <= i_cfg_data;
                CFG_ADR_LEN:   r_adr_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    scfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_s_tdata),
        .i_block_len (r_block_len),
        .i_xfer_len  (r_xfer_len),
        .i_adr_len   (r_adr_len),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_out_valid <= w_accept && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.version, r_out.index, r_out.payload};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;

endmodule
`default_nettype wire

>>> rtl/scfp_core.sv
`default_nettype none
module scfp_core
    import scfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_block_len,
    input  wire logic [7:0] i_xfer_len,
    input  wire logic [7:0] i_adr_len,
    output logic            o_res_valid,
    output t_result         o_res
);

    t_state           r_state, n_state;
    logic [3:0][7:0]  r_win, n_win;
    logic [7:0]       r_cnt, n_cnt;
    logic [1:0]       r_vcnt, n_vcnt;
    logic [7:0]       w_len;
    logic [3:0][7:0]  w_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HEADER;
            r_win   <= '0;
            r_cnt   <= '0;
            r_vcnt  <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_win   <= n_win;
            r_cnt   <= n_cnt;
            r_vcnt  <= n_vcnt;
        end
    end

    assign w_shift = {i_byte, r_win[3], r_win[2], r_win[1]};

    always_comb begin
        n_state     = r_state;
        n_win       = r_win;
        n_cnt       = r_cnt;
        n_vcnt      = r_vcnt;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_len       = i_xfer_len;
        unique case (r_state)
            ST_BLOCK, ST_XFC, ST_XTO, ST_ADR: begin
                unique case (r_state)
                    ST_BLOCK: begin
                        w_len      = i_block_len;
                        o_res.kind = EV_BLOCK;
                    end
                    ST_ADR: begin
                        w_len      = i_adr_len;
                        o_res.kind = EV_ADR;
                    end
                    ST_XFC:  o_res.kind = EV_XFC;
                    default: o_res.kind = EV_XTO;
                endcase
                n_cnt         = r_cnt + 8'd1;
                o_res_valid   = 1'b1;
                o_res.payload = i_byte;
                o_res.index   = r_cnt;
                o_res.last    = (n_cnt == w_len);
                if (o_res.last) begin
                    n_state = ST_HEADER;
                end
            end
            ST_VER: begin
                n_win[r_vcnt] = i_byte;
                n_vcnt        = r_vcnt + 2'd1;
                if (r_vcnt == 2'd3) begin
                    n_state       = ST_HEADER;
                    o_res_valid   = 1'b1;
                    o_res.kind    = EV_VERSION;
                    o_res.version = parse_version(n_win);
                end
            end
            default: begin
                n_state = ST_HEADER;
                n_win   = w_shift;
                priority if (w_shift == HDR_VER) begin
                    n_state = ST_VER;
                end else if (w_shift == HDR_RQB) begin
                    n_state = ST_BLOCK;
                end else if (w_shift == HDR_ADR) begin
                    n_state = ST_ADR;
                end else if (w_shift == HDR_XFC) begin
                    n_state = ST_XFC;
                end else if (w_shift == HDR_XTO) begin
                    n_state = ST_XTO;
                end else if (w_shift == HDR_BST) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = EV_SYNC;
                end else begin
                    n_state = ST_HEADER;
                end
                if (n_state != ST_HEADER) begin
                    n_win  = '0;
                    n_cnt  = '0;
                    n_vcnt = '0;
                end
            end
        endcase
    end

`ifndef SYNTHESIS
    a_last_ends_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_state == ST_BLOCK || r_state == ST_XFC || r_state == ST_XTO
            || r_state == ST_ADR) && n_cnt == w_len |=> r_state == ST_HEADER)
        else $error("packet did not end on its last byte");
    a_vcnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_VER |-> r_vcnt == 2'd0)
        else $error("version count nonzero outside version state");
    a_version_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_state == ST_VER && r_vcnt == 2'd3
            |-> o_res_valid && o_res.kind == EV_VERSION)
        else $error("fourth version character gave no version event");
    a_sync_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_state == ST_HEADER && o_res_valid |=> r_state == ST_HEADER)
        else $error("sync event left header search");
`endif

endmodule
`default_nettype wire
